// File: rtl/ioc_pkg.sv
// Shared types, codes and constants for the IMU offset calibrator.
// Used by every module under rtl/; depends on nothing else.
`timescale 1ns / 1ps

package ioc_pkg;

   // Request codes carried in the input tuser.
   localparam logic [1:0] REQ_SAMPLE   = 2'd0;
   localparam logic [1:0] REQ_ACC_CAL  = 2'd1;
   localparam logic [1:0] REQ_GYRO_CAL = 2'd2;

   localparam int AXES     = 3;
   localparam int ACC_AXES = 2;   // only X and Y carry a correction
   localparam int DATA_W   = 16;
   localparam int REQ_W    = 2;
   localparam int STAT_W   = 5;

   localparam int                  THRESH_W     = 22;
   localparam logic [THRESH_W-1:0] THRESH_RESET = 22'd2000;
   localparam logic [THRESH_W-1:0] MOTION_MAX   = {THRESH_W{1'b1}};

   localparam int ACC_CAL_SAMPLES  = 200;
   localparam int GYRO_CAL_SAMPLES = 50;

   // Counters run 0 .. N-1.
   localparam int ACC_CNT_W  = $clog2(ACC_CAL_SAMPLES);
   localparam int GYRO_CNT_W = $clog2(GYRO_CAL_SAMPLES);

   // A full window sum has magnitude at most N * 2^15.
   localparam int ACC_MAG_W  = $clog2(ACC_CAL_SAMPLES * (2 ** (DATA_W - 1)) + 1);
   localparam int GYRO_MAG_W = $clog2(GYRO_CAL_SAMPLES * (2 ** (DATA_W - 1)) + 1);
   localparam int ACC_SUM_W  = ACC_MAG_W + 1;
   localparam int GYRO_SUM_W = GYRO_MAG_W + 1;

   // Reciprocal multiply: floor(x / N) = (x * ceil(2^S / N)) >> S is exact
   // for x below 2^S / N, which holds with S = magnitude width + count width.
   localparam int ACC_SHIFT   = ACC_MAG_W + ACC_CNT_W;
   localparam int GYRO_SHIFT  = GYRO_MAG_W + GYRO_CNT_W;
   localparam int ACC_PROD_W  = ACC_MAG_W + ACC_SHIFT;
   localparam int GYRO_PROD_W = GYRO_MAG_W + GYRO_SHIFT;

   localparam logic [ACC_SHIFT-1:0] ACC_RECIP = ACC_SHIFT'(
      ((64'd1 << ACC_SHIFT) + 64'(ACC_CAL_SAMPLES - 1)) / 64'(ACC_CAL_SAMPLES));
   localparam logic [GYRO_SHIFT-1:0] GYRO_RECIP = GYRO_SHIFT'(
      ((64'd1 << GYRO_SHIFT) + 64'(GYRO_CAL_SAMPLES - 1)) / 64'(GYRO_CAL_SAMPLES));

   // Input stall after a completing sample while the offsets are divided.
   localparam int             HOLD_W      = 2;
   localparam logic [HOLD_W-1:0] HOLD_CYCLES = 2'd2;

   // Per-beat commands from the control unit to the lanes.
   typedef struct packed {
      logic acc_clear;
      logic acc_add;
      logic acc_done;
      logic gyro_clear;
      logic gyro_add;
      logic gyro_restart;
      logic gyro_done;
   } lane_ctrl_type;

   // Status flags of one result beat; acc_busy lands in the lowest bit.
   typedef struct packed {
      logic rejected;
      logic gyro_done;
      logic gyro_busy;
      logic acc_done;
      logic acc_busy;
   } status_type;

endpackage

// File: rtl/ioc_acc_lane.sv
// One acceleration axis lane: offset removal, calibration sum and offset divide.
// Depends on ioc_pkg.
`timescale 1ns / 1ps

module ioc_acc_lane (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ioc_pkg::lane_ctrl_type               ctrl,
   input  logic signed [ioc_pkg::DATA_W-1:0]    raw,
   output logic signed [ioc_pkg::DATA_W-1:0]    corr
);
   import ioc_pkg::*;

   logic signed [ACC_SUM_W-1:0]  sum_ff, sum_in;
   logic signed [ACC_SUM_W-1:0]  sum_neg;
   logic signed [DATA_W-1:0]     offset_ff, offset_in;
   logic [ACC_MAG_W-1:0]         mag;
   logic [ACC_PROD_W-1:0]        prod_ff;
   logic [DATA_W-1:0]            quot;
   logic                         neg_ff;
   logic                         div_v_ff;
   logic                         prod_v_ff;

   // Corrected output, wrapped to the data width.
   assign corr = raw - offset_ff;

   // Running sum of the calibration samples.
   always_comb begin
      sum_in = sum_ff;
      if (ctrl.acc_clear) begin
         sum_in = '0;
      end else if (ctrl.acc_add) begin
         sum_in = sum_ff + ACC_SUM_W'(raw);
      end
   end

   // Divide by the sample count through the magnitude, so it truncates toward zero.
   assign sum_neg = -sum_ff;
   assign mag     = sum_ff[ACC_SUM_W-1] ? sum_neg[ACC_MAG_W-1:0] : sum_ff[ACC_MAG_W-1:0];
   assign quot    = prod_ff[ACC_SHIFT +: DATA_W];

   always_comb begin
      offset_in = offset_ff;
      if (ctrl.acc_clear) begin
         offset_in = '0;
      end else if (prod_v_ff) begin
         offset_in = neg_ff ? $signed(DATA_W'(-quot)) : $signed(quot);
      end
   end

   // State and divide pipeline.
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff    <= '0;
         offset_ff <= '0;
         div_v_ff  <= 1'b0;
         prod_v_ff <= 1'b0;
      end else begin
         sum_ff    <= sum_in;
         offset_ff <= offset_in;
         div_v_ff  <= ctrl.acc_done;
         prod_v_ff <= div_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (div_v_ff) begin
         prod_ff <= ACC_PROD_W'(mag) * ACC_PROD_W'(ACC_RECIP);
         neg_ff  <= sum_ff[ACC_SUM_W-1];
      end
   end

endmodule

// File: rtl/ioc_gyro_lane.sv
// One gyro axis lane: offset removal, window sum, motion sum and offset divide.
// Depends on ioc_pkg.
`timescale 1ns / 1ps

module ioc_gyro_lane (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ioc_pkg::lane_ctrl_type               ctrl,
   input  logic [ioc_pkg::THRESH_W-1:0]         threshold,
   input  logic signed [ioc_pkg::DATA_W-1:0]    raw,
   output logic signed [ioc_pkg::DATA_W-1:0]    corr,
   output logic                                 motion_hit
);
   import ioc_pkg::*;

   logic signed [GYRO_SUM_W-1:0] sum_ff, sum_in;
   logic signed [GYRO_SUM_W-1:0] sum_neg;
   logic [THRESH_W-1:0]          motion_ff, motion_in;
   logic [THRESH_W-1:0]          motion_sat;
   logic [THRESH_W:0]            motion_add;
   logic signed [DATA_W-1:0]     prev_ff, prev_in;
   logic signed [DATA_W:0]       delta;
   logic signed [DATA_W:0]       delta_neg;
   logic [DATA_W-1:0]            delta_abs;
   logic signed [DATA_W-1:0]     offset_ff, offset_in;
   logic [GYRO_MAG_W-1:0]        mag;
   logic [GYRO_PROD_W-1:0]       prod_ff;
   logic [DATA_W-1:0]            quot;
   logic                         neg_ff;
   logic                         div_v_ff;
   logic                         prod_v_ff;

   assign corr = raw - offset_ff;

   // Absolute change from the previous sample, added with saturation.
   assign delta      = (DATA_W + 1)'(prev_ff) - (DATA_W + 1)'(raw);
   assign delta_neg  = -delta;
   assign delta_abs  = delta[DATA_W] ? delta_neg[DATA_W-1:0] : delta[DATA_W-1:0];
   assign motion_add = {1'b0, motion_ff} + (THRESH_W + 1)'(delta_abs);
   assign motion_sat = motion_add[THRESH_W] ? MOTION_MAX : motion_add[THRESH_W-1:0];
   assign motion_hit = (motion_sat >= threshold);

   // Window state; a rejected window restarts its sums but keeps the previous sample.
   always_comb begin
      sum_in    = sum_ff;
      motion_in = motion_ff;
      prev_in   = prev_ff;
      if (ctrl.gyro_clear) begin
         sum_in    = '0;
         motion_in = '0;
         prev_in   = '0;
      end else if (ctrl.gyro_add) begin
         prev_in = raw;
         if (ctrl.gyro_restart) begin
            sum_in    = '0;
            motion_in = '0;
         end else begin
            sum_in    = sum_ff + GYRO_SUM_W'(raw);
            motion_in = motion_sat;
         end
      end
   end

   // Divide by the window length, truncating toward zero.
   assign sum_neg = -sum_ff;
   assign mag     = sum_ff[GYRO_SUM_W-1] ? sum_neg[GYRO_MAG_W-1:0] : sum_ff[GYRO_MAG_W-1:0];
   assign quot    = prod_ff[GYRO_SHIFT +: DATA_W];

   always_comb begin
      offset_in = offset_ff;
      if (prod_v_ff) begin
         offset_in = neg_ff ? $signed(DATA_W'(-quot)) : $signed(quot);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff    <= '0;
         motion_ff <= '0;
         prev_ff   <= '0;
         offset_ff <= '0;
         div_v_ff  <= 1'b0;
         prod_v_ff <= 1'b0;
      end else begin
         sum_ff    <= sum_in;
         motion_ff <= motion_in;
         prev_ff   <= prev_in;
         offset_ff <= offset_in;
         div_v_ff  <= ctrl.gyro_done;
         prod_v_ff <= div_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (div_v_ff) begin
         prod_ff <= GYRO_PROD_W'(mag) * GYRO_PROD_W'(GYRO_RECIP);
         neg_ff  <= sum_ff[GYRO_SUM_W-1];
      end
   end

endmodule

// File: rtl/ioc_ctrl.sv
// Calibration control: sample counters, merge of the lanes' motion flags,
// lane commands and the input hold after a completed calibration. Depends on ioc_pkg.
`timescale 1ns / 1ps

module ioc_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [ioc_pkg::REQ_W-1:0]     req_type,
   input  logic [ioc_pkg::AXES-1:0]      motion_hit,
   output ioc_pkg::lane_ctrl_type        lane_ctrl,
   output ioc_pkg::status_type           status,
   output logic                          stall
);
   import ioc_pkg::*;

   logic [ACC_CNT_W-1:0]  acc_count_ff, acc_count_in;
   logic [GYRO_CNT_W-1:0] gyro_count_ff, gyro_count_in;
   logic                  acc_active_ff, acc_active_in;
   logic                  gyro_active_ff, gyro_active_in;
   logic [HOLD_W-1:0]     hold_ff, hold_in;
   logic                  is_sample;
   logic                  acc_end;
   logic                  gyro_end;
   logic                  moved;

   assign is_sample = accept && (req_type == REQ_SAMPLE);
   assign acc_end   = (acc_count_ff == ACC_CNT_W'(ACC_CAL_SAMPLES - 1));
   assign gyro_end  = (gyro_count_ff == GYRO_CNT_W'(GYRO_CAL_SAMPLES - 1));
   assign moved     = |motion_hit;

   // Commands for the lanes in this beat.
   always_comb begin
      lane_ctrl.acc_clear    = accept && (req_type == REQ_ACC_CAL);
      lane_ctrl.acc_add      = is_sample && acc_active_ff;
      lane_ctrl.acc_done     = is_sample && acc_active_ff && acc_end;
      lane_ctrl.gyro_clear   = accept && (req_type == REQ_GYRO_CAL);
      lane_ctrl.gyro_add     = is_sample && gyro_active_ff;
      lane_ctrl.gyro_restart = is_sample && gyro_active_ff && gyro_end && moved;
      lane_ctrl.gyro_done    = is_sample && gyro_active_ff && gyro_end && !moved;
   end

   // Counter and activity updates.
   always_comb begin
      acc_count_in   = acc_count_ff;
      acc_active_in  = acc_active_ff;
      gyro_count_in  = gyro_count_ff;
      gyro_active_in = gyro_active_ff;
      if (lane_ctrl.acc_clear) begin
         acc_count_in  = '0;
         acc_active_in = 1'b1;
      end else if (lane_ctrl.acc_add) begin
         acc_count_in = acc_end ? '0 : acc_count_ff + 1'b1;
         if (acc_end) begin
            acc_active_in = 1'b0;
         end
      end
      if (lane_ctrl.gyro_clear) begin
         gyro_count_in  = '0;
         gyro_active_in = 1'b1;
      end else if (lane_ctrl.gyro_add) begin
         gyro_count_in = gyro_end ? '0 : gyro_count_ff + 1'b1;
         if (lane_ctrl.gyro_done) begin
            gyro_active_in = 1'b0;
         end
      end
   end

   // Hold the input while the lanes divide out the new offsets.
   always_comb begin
      hold_in = hold_ff;
      if (lane_ctrl.acc_done || lane_ctrl.gyro_done) begin
         hold_in = HOLD_CYCLES;
      end else if (hold_ff != '0) begin
         hold_in = hold_ff - 1'b1;
      end
   end

   assign stall = (hold_ff != '0);

   // Flags reported with this beat's result.
   always_comb begin
      status.acc_busy  = acc_active_in;
      status.acc_done  = lane_ctrl.acc_done;
      status.gyro_busy = gyro_active_in;
      status.gyro_done = lane_ctrl.gyro_done;
      status.rejected  = lane_ctrl.gyro_restart;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_count_ff   <= '0;
         acc_active_ff  <= 1'b0;
         gyro_count_ff  <= '0;
         gyro_active_ff <= 1'b0;
         hold_ff        <= '0;
      end else begin
         acc_count_ff   <= acc_count_in;
         acc_active_ff  <= acc_active_in;
         gyro_count_ff  <= gyro_count_in;
         gyro_active_ff <= gyro_active_in;
         hold_ff        <= hold_in;
      end
   end

endmodule

// File: rtl/imu_offset_calibrator_top.sv
// IMU offset calibrator: the rsp beat of an accepted req beat is registered and is
// offered in the cycle after. Throughput is one item per cycle while rsp_tready holds
// no beat back; after a beat that completes a calibration the input stalls while each
// lane's reciprocal multiply forms the offsets. Synchronous active-high reset clears
// offsets, sums, counters and the output valid, and sets the motion threshold to 2000.
`timescale 1ns / 1ps

module imu_offset_calibrator_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // raw_acc_x, raw_acc_y, raw_acc_z, raw_gyro_x, raw_gyro_y, raw_gyro_z
   input  logic [6*ioc_pkg::DATA_W-1:0]         req_tdata,
   // req_type
   input  logic [ioc_pkg::REQ_W-1:0]            req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // acc_x, acc_y, acc_z, rate_x, rate_y, rate_z
   output logic [6*ioc_pkg::DATA_W-1:0]         rsp_tdata,
   // acc_cal_busy, acc_cal_done, gyro_cal_busy, gyro_cal_done, gyro_window_rejected
   output logic [ioc_pkg::STAT_W-1:0]           rsp_tuser,
   input  logic                                 csr_wr_en,
   input  logic [ioc_pkg::THRESH_W-1:0]         csr_wr_data
);
   import ioc_pkg::*;

   lane_ctrl_type            lane_ctrl;
   status_type               status;
   logic                     stall;
   logic                     out_ready;
   logic                     accept;
   logic [THRESH_W-1:0]      thresh_ff;
   logic [AXES-1:0]          motion_hit;
   logic signed [DATA_W-1:0] acc_raw  [ACC_AXES];
   logic signed [DATA_W-1:0] acc_corr [ACC_AXES];
   logic signed [DATA_W-1:0] gyro_raw  [AXES];
   logic signed [DATA_W-1:0] gyro_corr [AXES];
   logic [6*DATA_W-1:0]      data_in;
   logic [6*DATA_W-1:0]      tdata_ff;
   logic [STAT_W-1:0]        tuser_ff;
   logic                     tvalid_ff;

   // Handshake: the output register frees up as its beat is taken.
   assign out_ready  = !tvalid_ff || rsp_tready;
   assign req_tready = out_ready && !stall;
   assign accept     = req_tvalid && req_tready;

   // Motion threshold register.
   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= THRESH_RESET;
      end else if (csr_wr_en) begin
         thresh_ff <= csr_wr_data;
      end
   end

   ioc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req_type   (req_tuser),
      .motion_hit (motion_hit),
      .lane_ctrl  (lane_ctrl),
      .status     (status),
      .stall      (stall)
   );

   // Accel lanes for X and Y; Z is never corrected, so its offset is not kept.
   for (genvar i = 0; i < ACC_AXES; i++) begin : g_acc
      assign acc_raw[i] = req_tdata[i*DATA_W +: DATA_W];
      ioc_acc_lane u_lane (
         .clock (clock),
         .reset (reset),
         .ctrl  (lane_ctrl),
         .raw   (acc_raw[i]),
         .corr  (acc_corr[i])
      );
   end

   // Gyro lanes, one per axis.
   for (genvar i = 0; i < AXES; i++) begin : g_gyro
      assign gyro_raw[i] = req_tdata[(AXES + i)*DATA_W +: DATA_W];
      ioc_gyro_lane u_lane (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (lane_ctrl),
         .threshold  (thresh_ff),
         .raw        (gyro_raw[i]),
         .corr       (gyro_corr[i]),
         .motion_hit (motion_hit[i])
      );
   end

   // Result data: corrected sample, or zeros for a request beat.
   always_comb begin
      data_in = '0;
      if (req_tuser == REQ_SAMPLE) begin
         data_in = {gyro_corr[2], gyro_corr[1], gyro_corr[0],
                    req_tdata[2*DATA_W +: DATA_W], acc_corr[1], acc_corr[0]};
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         tvalid_ff <= 1'b0;
      end else if (out_ready) begin
         tvalid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         tdata_ff <= data_in;
         tuser_ff <= status;
      end
   end

   assign rsp_tvalid = tvalid_ff;
   assign rsp_tdata  = tdata_ff;
   assign rsp_tuser  = tuser_ff;

   // A finished calibration is never reported as still busy.
   a_done_not_busy : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[1] && rsp_tuser[0]) && !(rsp_tuser[3] && rsp_tuser[2]))
      else $error("calibration reported done and busy together");

   // A gyro window either completes or is rejected, not both.
   a_done_or_reject : assert property (@(posedge clock) disable iff (reset)
      !(lane_ctrl.gyro_done && lane_ctrl.gyro_restart))
      else $error("gyro window both accepted and rejected");

   // No beat enters while the new offsets are still being divided.
   a_hold_after_done : assert property (@(posedge clock) disable iff (reset)
      (lane_ctrl.acc_done || lane_ctrl.gyro_done) |=> !req_tready ##1 !req_tready)
      else $error("input accepted before offsets were updated");

endmodule

// File: dv/imu_calib_checker_pkg.sv
// Scoreboard for the IMU offset calibrator: predicts each rsp beat from the accepted req beats.
// Depends on ioc_pkg for field widths, request codes, status layout and calibration constants.
`timescale 1ns / 1ps

package imu_calib_checker_pkg;

   import ioc_pkg::*;

   // Request code that starts nothing; the block still answers it with an all-zero data beat.
   localparam logic [REQ_W-1:0] REQ_IGNORED = 2'd3;
   localparam int               BEAT_W      = 6 * DATA_W;
   localparam int               PRINT_LIMIT = 200;

   typedef struct {
      logic [BEAT_W-1:0] fields;
      status_type        flags;
   } corrected_beat_type;

   class calib_checker;

      // Shadow copy of the calibrator state, mostly at the block's widths; rate_total and rate_n are wider.
      logic signed [DATA_W-1:0]   acc_ofs[AXES];
      logic signed [DATA_W-1:0]   rate_ofs[AXES];
      logic signed [DATA_W-1:0]   last_rate[AXES];
      logic signed [23:0]         acc_total[AXES];
      logic signed [22:0]         rate_total[AXES];
      logic        [THRESH_W-1:0] motion[AXES];
      logic        [7:0]          acc_n;
      logic        [7:0]          rate_n;
      bit                         acc_on;
      bit                         rate_on;
      logic        [THRESH_W-1:0] threshold;

      corrected_beat_type corrected_q[$];
      int unsigned        beat_index;
      int unsigned        mismatches;

      function new();
         for (int i = 0; i < AXES; i++) begin
            acc_ofs[i]    = '0;
            rate_ofs[i]   = '0;
            last_rate[i]  = '0;
            acc_total[i]  = '0;
            rate_total[i] = '0;
            motion[i]     = '0;
         end
         acc_n      = '0;
         rate_n     = '0;
         acc_on     = 1'b0;
         rate_on    = 1'b0;
         threshold  = THRESH_RESET;
         beat_index = 0;
         mismatches = 0;
      endfunction

      function void set_threshold(logic [THRESH_W-1:0] value);
         threshold = value;
      endfunction

      function int pending();
         return corrected_q.size();
      endfunction

      // Apply one accepted req beat to the shadow state and queue the beat it must produce.
      function void absorb_request(logic [REQ_W-1:0] kind, logic [BEAT_W-1:0] payload);
         logic signed [DATA_W-1:0] raw[6];
         logic signed [DATA_W-1:0] fixed[6];
         corrected_beat_type       beat;
         int                       step;
         int                       total;
         bit                       moved;
         for (int i = 0; i < 6; i++) begin
            raw[i]   = payload[i*DATA_W +: DATA_W];
            fixed[i] = '0;
         end
         beat.flags = '0;

         case (kind)
            REQ_ACC_CAL: begin
               for (int i = 0; i < AXES; i++) begin
                  acc_ofs[i]   = '0;
                  acc_total[i] = '0;
               end
               acc_n  = '0;
               acc_on = 1'b1;
            end
            REQ_GYRO_CAL: begin
               for (int i = 0; i < AXES; i++) begin
                  rate_total[i] = '0;
                  motion[i]     = '0;
                  last_rate[i]  = '0;
               end
               rate_n  = '0;
               rate_on = 1'b1;
            end
            REQ_SAMPLE: begin
               // Outputs always use the offsets held before this beat.
               fixed[0] = raw[0] - acc_ofs[0];
               fixed[1] = raw[1] - acc_ofs[1];
               fixed[2] = raw[2];
               for (int i = 0; i < AXES; i++)
                  fixed[AXES+i] = raw[AXES+i] - rate_ofs[i];

               if (acc_on) begin
                  for (int i = 0; i < AXES; i++)
                     acc_total[i] = acc_total[i] + raw[i];
                  acc_n = acc_n + 1'b1;
                  if (acc_n >= ACC_CAL_SAMPLES) begin
                     for (int i = 0; i < AXES; i++)
                        acc_ofs[i] = DATA_W'(acc_total[i] / ACC_CAL_SAMPLES);
                     acc_n          = '0;
                     acc_on         = 1'b0;
                     beat.flags.acc_done = 1'b1;
                  end
               end

               if (rate_on) begin
                  // Motion is the saturating sum of absolute steps between raw rates.
                  for (int i = 0; i < AXES; i++) begin
                     step = int'(last_rate[i]) - int'(raw[AXES+i]);
                     if (step < 0)
                        step = -step;
                     total = int'(motion[i]) + step;
                     motion[i] = (total > int'(MOTION_MAX)) ? MOTION_MAX : THRESH_W'(total);
                     rate_total[i] = rate_total[i] + raw[AXES+i];
                     last_rate[i]  = raw[AXES+i];
                  end
                  rate_n = rate_n + 1'b1;
                  if (rate_n >= GYRO_CAL_SAMPLES) begin
                     moved = 1'b0;
                     for (int i = 0; i < AXES; i++)
                        if (motion[i] >= threshold)
                           moved = 1'b1;
                     if (moved) begin
                        // A rejected window restarts, but the previous rate carries over.
                        for (int i = 0; i < AXES; i++) begin
                           rate_total[i] = '0;
                           motion[i]     = '0;
                        end
                        beat.flags.rejected = 1'b1;
                     end else begin
                        for (int i = 0; i < AXES; i++)
                           rate_ofs[i] = DATA_W'(rate_total[i] / GYRO_CAL_SAMPLES);
                        rate_on              = 1'b0;
                        beat.flags.gyro_done = 1'b1;
                     end
                     rate_n = '0;
                  end
               end
            end
            default: begin
            end
         endcase

         beat.flags.acc_busy  = acc_on;
         beat.flags.gyro_busy = rate_on;
         for (int i = 0; i < 6; i++)
            beat.fields[i*DATA_W +: DATA_W] = fixed[i];
         corrected_q.push_back(beat);
      endfunction

      task report_mismatch(string detail);
         if (mismatches < PRINT_LIMIT)
            $display("[%0t] rsp beat %0d: %s", $time, beat_index, detail);
         mismatches++;
      endtask

      // Compare one accepted rsp beat with the oldest prediction, field by field.
      task check_output(logic [BEAT_W-1:0] data, logic [STAT_W-1:0] user);
         string              field_names[6] = '{"acc_x", "acc_y", "acc_z",
                                                "rate_x", "rate_y", "rate_z"};
         string              flag_names[STAT_W] = '{"acc_cal_busy", "acc_cal_done",
                                                    "gyro_cal_busy", "gyro_cal_done",
                                                    "gyro_window_rejected"};
         corrected_beat_type want;
         logic [STAT_W-1:0]  want_bits;
         if (corrected_q.size() == 0) begin
            report_mismatch("beat arrived with no prediction waiting");
         end else begin
            want      = corrected_q.pop_front();
            want_bits = want.flags;
            for (int i = 0; i < 6; i++)
               if (data[i*DATA_W +: DATA_W] !== want.fields[i*DATA_W +: DATA_W])
                  report_mismatch($sformatf("%s got %h want %h", field_names[i],
                                            data[i*DATA_W +: DATA_W],
                                            want.fields[i*DATA_W +: DATA_W]));
            for (int i = 0; i < STAT_W; i++)
               if (user[i] !== want_bits[i])
                  report_mismatch($sformatf("%s got %b want %b", flag_names[i],
                                            user[i], want_bits[i]));
         end
         beat_index++;
      endtask

   endclass

endpackage

// File: dv/tb_top.sv
// Top-level testbench for imu_offset_calibrator_top: directed and random req beats,
// random back-pressure and threshold changes. Depends on ioc_pkg and imu_calib_checker_pkg.
`timescale 1ns / 1ps

module tb_top;

   import ioc_pkg::*;
   import imu_calib_checker_pkg::*;

   localparam int CYCLE_LIMIT     = 600000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int HOLD_OFF_AFTER  = 300;
   localparam int PHASE_ITEMS     = 260;
   localparam int DRAIN_CYCLES    = 4;

   typedef enum int {ACC_FULL, ACC_EDGE, ACC_NEAR_ZERO} acc_style_type;

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [BEAT_W-1:0]   req_tdata;
   logic [REQ_W-1:0]    req_tuser;
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [BEAT_W-1:0]   rsp_tdata;
   logic [STAT_W-1:0]   rsp_tuser;
   logic                csr_wr_en;
   logic [THRESH_W-1:0] csr_wr_data;

   calib_checker offsets_sb;

   // Shape of the generated samples; reshuffled for every scenario.
   acc_style_type            acc_style;
   logic [DATA_W-1:0]        acc_edge_word;
   bit                       rate_noisy;
   int                       rate_amp;
   logic signed [DATA_W-1:0] rate_base[AXES];
   bit                       idle_free;

   int unsigned rsp_beats = 0;
   int unsigned cycles    = 0;

   imu_offset_calibrator_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Hard stop in case the block hangs.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Every accepted rsp beat is checked against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         offsets_sb.check_output(rsp_tdata, rsp_tuser);
         rsp_beats <= rsp_beats + 1;
      end
   end

   // Idle lengths: mostly none, some short, a few long.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 65)
         return 0;
      else if (roll < 92)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 40);
   endfunction

   function automatic logic [BEAT_W-1:0] random_payload();
      return {$urandom, $urandom, $urandom};
   endfunction

   function automatic logic [BEAT_W-1:0] make_sample();
      logic [BEAT_W-1:0] beat;
      logic [DATA_W-1:0] word;
      for (int i = 0; i < AXES; i++) begin
         case (acc_style)
            ACC_FULL: word = DATA_W'($urandom);
            ACC_EDGE: word = acc_edge_word;
            default:  word = DATA_W'($urandom_range(0, 200)) - DATA_W'(100);
         endcase
         beat[i*DATA_W +: DATA_W] = word;
         if (rate_noisy)
            word = DATA_W'($urandom);
         else
            word = rate_base[i] + DATA_W'($urandom_range(0, 2 * rate_amp)) - DATA_W'(rate_amp);
         beat[(AXES+i)*DATA_W +: DATA_W] = word;
      end
      return beat;
   endfunction

   task automatic shuffle_styles();
      int pick;
      pick = $urandom_range(0, 9);
      acc_style     = (pick < 6) ? ACC_FULL : (pick < 8) ? ACC_EDGE : ACC_NEAR_ZERO;
      acc_edge_word = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
      rate_noisy    = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 2))
         0:       rate_amp = 0;
         1:       rate_amp = 8;
         default: rate_amp = 60;
      endcase
      // A still sensor at zero gives no motion at all, the edge case for tiny thresholds.
      for (int i = 0; i < AXES; i++)
         rate_base[i] = (rate_amp == 0 && $urandom_range(0, 1))
                        ? '0 : DATA_W'($urandom_range(0, 800)) - DATA_W'(400);
      idle_free = ($urandom_range(0, 3) == 0);
   endtask

   // Offer one req beat, hold it until accepted, then maybe idle.
   task automatic send_beat(input logic [REQ_W-1:0] kind, input logic [BEAT_W-1:0] payload);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= payload;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      offsets_sb.absorb_request(kind, payload);
      gap = idle_free ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stop offering and wait until every predicted beat has come back.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (offsets_sb.pending() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [THRESH_W-1:0] value);
      drain_results();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      offsets_sb.set_threshold(value);
      csr_wr_en <= 1'b0;
   endtask

   task automatic run_directed();
      idle_free = 1'b1;
      send_beat(REQ_SAMPLE, '0);
      send_beat(REQ_SAMPLE, {6{16'h8000}});
      send_beat(REQ_SAMPLE, {6{16'h7fff}});
      send_beat(REQ_SAMPLE, {6{16'hffff}});
      send_beat(REQ_SAMPLE, {3{32'haaaa5555}});
      send_beat(REQ_IGNORED, {6{16'h1234}});
      // Request data must not show up in the result.
      send_beat(REQ_ACC_CAL, {6{16'hffff}});
      send_beat(REQ_GYRO_CAL, {6{16'h8000}});
      idle_free = 1'b0;
      // Both calibrations run at once and take the same samples.
      repeat (4) send_beat(REQ_SAMPLE, random_payload());
      // Restart both while busy.
      send_beat(REQ_ACC_CAL, random_payload());
      send_beat(REQ_GYRO_CAL, random_payload());
      send_beat(REQ_SAMPLE, {6{16'h8000}});
      send_beat(REQ_SAMPLE, {6{16'h7fff}});
      send_beat(REQ_IGNORED, random_payload());
      send_beat(REQ_SAMPLE, '0);
   endtask

   // Mostly complete calibration runs with random content, plus plain samples and noise.
   task automatic run_phase(input int budget);
      int sent;
      int run_len;
      int choice;
      sent = 0;
      while (sent < budget) begin
         shuffle_styles();
         choice = $urandom_range(0, 99);
         if (choice < 30) begin
            send_beat(REQ_ACC_CAL, random_payload());
            run_len = ACC_CAL_SAMPLES + $urandom_range(0, 20);
            if ($urandom_range(0, 9) == 0)
               run_len = $urandom_range(5, 150);
         end else if (choice < 60) begin
            send_beat(REQ_GYRO_CAL, random_payload());
            run_len = GYRO_CAL_SAMPLES * $urandom_range(1, 3) + $urandom_range(0, 5);
         end else if (choice < 72) begin
            send_beat(REQ_ACC_CAL, random_payload());
            send_beat(REQ_GYRO_CAL, random_payload());
            run_len = ACC_CAL_SAMPLES + $urandom_range(0, 20);
         end else if (choice < 94) begin
            run_len = $urandom_range(10, 60);
         end else begin
            repeat ($urandom_range(5, 15))
               send_beat(REQ_W'($urandom_range(0, 3)), random_payload());
            run_len = 0;
         end
         repeat (run_len) send_beat(REQ_SAMPLE, make_sample());
         sent += run_len + 1;
      end
   endtask

   // Receiver: random stalls, calm stretches, and one long hold-off that fills the block.
   initial begin : rsp_side
      int stall_left;
      int stretch_left;
      bit calm;
      bit held_off;
      rsp_tready  <= 1'b0;
      stall_left   = 0;
      stretch_left = 0;
      calm         = 1'b0;
      held_off     = 1'b0;
      @(posedge clock);
      forever begin
         if (!held_off && rsp_beats >= HOLD_OFF_AFTER) begin
            held_off = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else begin
            if (stretch_left == 0) begin
               stretch_left = $urandom_range(20, 120);
               calm         = ($urandom_range(0, 3) == 0);
            end
            stretch_left--;
            if (stall_left > 0) begin
               rsp_tready <= 1'b0;
               stall_left--;
            end else begin
               rsp_tready <= 1'b1;
               if (!calm)
                  stall_left = pick_gap();
            end
            @(posedge clock);
         end
      end
   end

   // Sender: reset, directed beats, then random phases over several thresholds.
   initial begin : req_side
      offsets_sb = new();
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= REQ_SAMPLE;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      idle_free    = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      run_directed();
      run_phase(PHASE_ITEMS);
      // A zero threshold rejects every window.
      write_threshold('0);
      run_phase(PHASE_ITEMS);
      // The largest threshold accepts everything short of a saturated motion sum.
      write_threshold(MOTION_MAX);
      run_phase(PHASE_ITEMS);
      write_threshold(22'd1);
      run_phase(PHASE_ITEMS);
      write_threshold(THRESH_W'($urandom_range(100, 5000)));
      run_phase(PHASE_ITEMS);

      drain_results();
      repeat (10) @(posedge clock);
      if (offsets_sb.mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

// File: filelist.f
rtl/ioc_pkg.sv
rtl/ioc_acc_lane.sv
rtl/ioc_gyro_lane.sv
rtl/ioc_ctrl.sv
rtl/imu_offset_calibrator_top.sv
dv/imu_calib_checker_pkg.sv
dv/tb_top.sv
